[sv/ovng_pkg.sv]
package ovng_pkg;

	// Grid and image geometry (powers of two)
	localparam int GRID_SIZE  = 16;
	localparam int RESOLUTION = 2048;

	localparam int GRID_LOG2   = $clog2(GRID_SIZE);
	localparam int RES_LOG2    = $clog2(RESOLUTION);
	localparam int FRAC_BITS   = RES_LOG2 - GRID_LOG2;
	localparam int NUM_OCT     = RES_LOG2;
	localparam int GRID_ENTRIES = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W      = 2 * GRID_LOG2;

	// Port widths
	localparam int INDEX_W = 8;
	localparam int VALUE_W = 16;
	localparam int PIXEL_W = 11;
	localparam int NOISE_W = 17;

	// Datapath widths
	localparam int COORD_W = FRAC_BITS + GRID_LOG2;
	localparam int WGT_W   = FRAC_BITS + 1;
	localparam int OP_W    = VALUE_W + FRAC_BITS;
	localparam int ACC_W   = VALUE_W + 2 * FRAC_BITS;
	localparam int PROD_W  = OP_W + WGT_W;
	localparam int OCT_W   = $clog2(NUM_OCT);

	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

	typedef logic [VALUE_W-1:0] grid_word_t;

endpackage

[sv/octave_value_noise_generator.sv]
// Channel   | Handshake        | Payload
// ----------+------------------+----------------------------------------------
// command   | start / busy     | action, grid_index, grid_value, pixel_x, pixel_y
// result    | done (strobe)    | noise_value
//
// A grid write leaves busy low. A pixel runs 11 octaves, each as a sequence
// of phases: one issues the first grid read, the one shared multiply-accumulate
// unit takes six products, and one adds the octave into the sum.
// done pulses when the last octave has been summed, and busy is low in that cycle.
// arst_n clears the sequencer and the strobe; the grid memory is not cleared.
// The receiver cannot stall: done is a one-cycle strobe; noise_value holds until the next result.
module octave_value_noise_generator
	import ovng_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [INDEX_W-1:0] grid_index,
	input  logic [VALUE_W-1:0] grid_value,
	input  logic [PIXEL_W-1:0] pixel_x,
	input  logic [PIXEL_W-1:0] pixel_y,
	output logic               done,
	output logic [NOISE_W-1:0] noise_value
);

	localparam logic [2:0] PH_READ00  = 3'd0;
	localparam logic [2:0] PH_MUL00   = 3'd1;
	localparam logic [2:0] PH_MUL10   = 3'd2;
	localparam logic [2:0] PH_MUL01   = 3'd3;
	localparam logic [2:0] PH_MUL11   = 3'd4;
	localparam logic [2:0] PH_MULB    = 3'd5;
	localparam logic [2:0] PH_MULA    = 3'd6;
	localparam logic [2:0] PH_SUM     = 3'd7;

	localparam logic [OCT_W-1:0] LAST_OCT = OCT_W'(NUM_OCT - 1);

	grid_word_t grid_mem [GRID_ENTRIES];

	logic               busy_q;
	logic [2:0]         phase_q;
	logic [OCT_W-1:0]   oct_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [ACC_W-1:0]   acc_q;
	logic [OP_W-1:0]    a_q;
	logic [NOISE_W-1:0] sum_q;
	grid_word_t         rd_q;
	logic               done_q;
	logic [NOISE_W-1:0] noise_q;

	logic                 accept;
	logic                 wr_en;
	logic [GRID_LOG2-1:0] cx, cy, cx1, cy1;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [WGT_W-1:0]     wx0, wy0;
	logic [ADDR_W-1:0]    rd_addr;
	logic [OP_W-1:0]      mac_op;
	logic [WGT_W-1:0]     mac_wgt;
	logic                 mac_clear;
	logic [PROD_W-1:0]    mac_prod;
	logic [ACC_W-1:0]     acc_d;
	logic [VALUE_W-1:0]   oct_m;
	logic [NOISE_W-1:0]   sum_d;

	assign accept = start && !busy_q;
	assign wr_en  = accept && !action && (32'(grid_index) < GRID_ENTRIES);

	// Cell and fraction come straight out of the scaled coordinate bits
	assign fx  = px_q[FRAC_BITS-1:0];
	assign fy  = py_q[FRAC_BITS-1:0];
	assign cx  = px_q[COORD_W-1:FRAC_BITS];
	assign cy  = py_q[COORD_W-1:FRAC_BITS];
	assign cx1 = cx + GRID_LOG2'(1);
	assign cy1 = cy + GRID_LOG2'(1);
	assign wx0 = WGT_ONE - WGT_W'(fx);
	assign wy0 = WGT_ONE - WGT_W'(fy);

	always_comb begin
		unique case (phase_q)
			PH_READ00: rd_addr = {cy, cx};
			PH_MUL00:  rd_addr = {cy, cx1};
			PH_MUL10:  rd_addr = {cy1, cx};
			PH_MUL01:  rd_addr = {cy1, cx1};
			default:   rd_addr = {cy, cx};
		endcase
	end

	always_comb begin
		unique case (phase_q)
			PH_MUL00: begin
				mac_op = OP_W'(rd_q); mac_wgt = wx0; mac_clear = 1'b1;
			end
			PH_MUL10: begin
				mac_op = OP_W'(rd_q); mac_wgt = WGT_W'(fx); mac_clear = 1'b0;
			end
			PH_MUL01: begin
				mac_op = OP_W'(rd_q); mac_wgt = wx0; mac_clear = 1'b1;
			end
			PH_MUL11: begin
				mac_op = OP_W'(rd_q); mac_wgt = WGT_W'(fx); mac_clear = 1'b0;
			end
			PH_MULB: begin
				mac_op = OP_W'(acc_q); mac_wgt = WGT_W'(fy); mac_clear = 1'b1;
			end
			PH_MULA: begin
				mac_op = a_q; mac_wgt = wy0; mac_clear = 1'b0;
			end
			default: begin
				mac_op = '0; mac_wgt = '0; mac_clear = 1'b0;
			end
		endcase
	end

	assign mac_prod = PROD_W'(mac_op) * PROD_W'(mac_wgt);
	assign acc_d    = ACC_W'(mac_prod) + (mac_clear ? '0 : acc_q);

	assign oct_m = acc_q[2*FRAC_BITS +: VALUE_W] >> oct_q;
	assign sum_d = sum_q + NOISE_W'(oct_m);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[grid_index[ADDR_W-1:0]] <= grid_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && action) begin
			px_q  <= COORD_W'(pixel_x);
			py_q  <= COORD_W'(pixel_y);
			sum_q <= '0;
		end else if (busy_q) begin
			if (phase_q != PH_SUM) begin
				acc_q <= acc_d;
			end
			if (phase_q == PH_MUL01) begin
				a_q <= OP_W'(acc_q);
			end
			if (phase_q == PH_SUM) begin
				sum_q <= sum_d;
				// advance to the next octave: double the coordinate
				px_q  <= px_q << 1;
				py_q  <= py_q << 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_READ00;
			oct_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && action) begin
				busy_q  <= 1'b1;
				phase_q <= PH_READ00;
				oct_q   <= '0;
			end else if (busy_q) begin
				phase_q <= phase_q + 3'd1;
				if (phase_q == PH_SUM) begin
					if (oct_q == LAST_OCT) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						oct_q <= oct_q + OCT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && phase_q == PH_SUM && oct_q == LAST_OCT) begin
			noise_q <= sum_d;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign noise_value = noise_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("result strobe without a finished computation");

	a_pixel_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action |=> busy_q && phase_q == PH_READ00 && oct_q == '0)
		else $error("pixel transaction did not start the sequencer");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !action |=> !busy_q && !done_q)
		else $error("grid write disturbed the sequencer");

	a_oct_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> oct_q <= LAST_OCT)
		else $error("octave counter out of range");

endmodule

[tb/sv/tb_octave_value_noise_generator.sv]
`timescale 1ns / 100ps

module tb_octave_value_noise_generator;
	import ovng_pkg::*;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	localparam int CYCLE_LIMIT   = 1_200_000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int RANDOM_ITEMS  = 1100;

	class noise_scoreboard;
		grid_word_t             grid_copy [GRID_ENTRIES];
		logic [NOISE_W-1:0]     expected_noise [$];
		int                     errors;

		function new();
			errors = 0;
			foreach (grid_copy[i])
				grid_copy[i] = '0;
		endfunction

		function bit [31:0] grid_at(int x, int y);
			return grid_copy[(y % GRID_SIZE) * GRID_SIZE + (x % GRID_SIZE)];
		endfunction

		function logic [NOISE_W-1:0] turbulence(logic [PIXEL_W-1:0] px,
			logic [PIXEL_W-1:0] py);
			bit [31:0] nx, ny, a, b, m, sum;
			bit [31:0] fx, fy;
			int        cx, cy, k;
			sum = 0;
			for (k = 0; k < NUM_OCT; k++) begin
				nx = (32'(px) * GRID_SIZE) << k;
				ny = (32'(py) * GRID_SIZE) << k;
				cx = (nx / RESOLUTION) % GRID_SIZE;
				cy = (ny / RESOLUTION) % GRID_SIZE;
				fx = ((nx % RESOLUTION) << FRAC_BITS) / RESOLUTION;
				fy = ((ny % RESOLUTION) << FRAC_BITS) / RESOLUTION;
				a = grid_at(cx, cy) * (32'(WGT_ONE) - fx) + grid_at(cx + 1, cy) * fx;
				b = grid_at(cx, cy + 1) * (32'(WGT_ONE) - fx)
					+ grid_at(cx + 1, cy + 1) * fx;
				m = (a * (32'(WGT_ONE) - fy) + b * fy) >> (2 * FRAC_BITS);
				sum += m >> k;
			end
			return NOISE_W'(sum);
		endfunction

		function void note_command(logic act, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] val, logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
			if (act == ACT_WRITE) begin
				if (idx < GRID_ENTRIES)
					grid_copy[idx] = val;
			end else begin
				expected_noise = {expected_noise, turbulence(px, py)};
			end
		endfunction

		function void check_noise(logic [NOISE_W-1:0] actual);
			logic [NOISE_W-1:0] want;
			if (expected_noise.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual noise_value %0h",
					$time, actual);
				errors++;
				return;
			end
			want = expected_noise.pop_front();
			if (actual !== want) begin
				$display("%0t: noise_value mismatch, expected %0h, actual %0h",
					$time, want, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_noise.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [INDEX_W-1:0] grid_index;
	logic [VALUE_W-1:0] grid_value;
	logic [PIXEL_W-1:0] pixel_x;
	logic [PIXEL_W-1:0] pixel_y;
	logic               done;
	logic [NOISE_W-1:0] noise_value;

	noise_scoreboard sb = new();
	int              cycles = 0;

	octave_value_noise_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.grid_index  (grid_index),
		.grid_value  (grid_value),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.done        (done),
		.noise_value (noise_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_noise(noise_value);
	end

	// Call at a rising edge; returns at the edge that accepts the transaction.
	// start stays high so a back-to-back transaction follows without a gap.
	task automatic send_command(logic act, logic [INDEX_W-1:0] idx,
		logic [VALUE_W-1:0] val, logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
		start      <= 1'b1;
		action     <= act;
		grid_index <= idx;
		grid_value <= val;
		pixel_x    <= px;
		pixel_y    <= py;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(act, idx, val, px, py);
	endtask

	task automatic write_cell(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
		send_command(ACT_WRITE, idx, val, PIXEL_W'($urandom), PIXEL_W'($urandom));
	endtask

	task automatic ask_pixel(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
		send_command(ACT_PIXEL, INDEX_W'($urandom), VALUE_W'($urandom), px, py);
	endtask

	task automatic idle_gap(int pct);
		int gap;
		gap = 0;
		while ($urandom_range(99) < pct)
			gap++;
		// now and then land the next start anywhere inside a pixel computation
		if (pct > 0 && $urandom_range(15) == 0)
			gap = $urandom_range(95);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [PIXEL_W-1:0] pick_coord();
		unique case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return PIXEL_W'(RESOLUTION / 2);
			3: return PIXEL_W'($urandom_range(127));
			default: return PIXEL_W'($urandom_range(RESOLUTION - 1));
		endcase
	endfunction

	task automatic run_random(int count, int pct);
		for (int i = 0; i < count; i++) begin
			idle_gap(pct);
			if ($urandom_range(99) < 35)
				write_cell(INDEX_W'($urandom), VALUE_W'($urandom));
			else
				ask_pixel(pick_coord(), pick_coord());
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		action     <= ACT_WRITE;
		grid_index <= '0;
		grid_value <= '0;
		pixel_x    <= '0;
		pixel_y    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every entry before any pixel reads the grid
		for (int i = 0; i < GRID_ENTRIES; i++)
			write_cell(INDEX_W'(i), '1);

		// Full-scale grid: the sum approaches its upper bound
		ask_pixel('0, '0);
		ask_pixel('1, '1);
		ask_pixel('1, '0);
		ask_pixel('0, '1);
		ask_pixel(PIXEL_W'(1024), PIXEL_W'(1023));

		write_cell('0, '0);
		write_cell(INDEX_W'(GRID_ENTRIES - 1), '0);
		write_cell(INDEX_W'(GRID_SIZE - 1), VALUE_W'(16'h8000));
		write_cell(INDEX_W'(GRID_ENTRIES - GRID_SIZE), VALUE_W'(16'h0001));
		// Corners of the grid: neighbour reads wrap around both edges
		ask_pixel('0, '0);
		ask_pixel('1, '1);
		ask_pixel('1, '0);
		ask_pixel('0, '1);
		ask_pixel(PIXEL_W'(127), PIXEL_W'(128));
		ask_pixel(PIXEL_W'(1), PIXEL_W'(2046));

		// Zero grid: every octave contributes nothing
		for (int i = 0; i < GRID_ENTRIES; i++)
			write_cell(INDEX_W'(i), '0);
		ask_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom));
		ask_pixel('1, '1);

		for (int i = 0; i < GRID_ENTRIES; i++)
			write_cell(INDEX_W'(i), VALUE_W'($urandom));
		ask_pixel('0, '0);
		ask_pixel('1, '1);
		ask_pixel(PIXEL_W'(64), PIXEL_W'(1984));

		run_random(RANDOM_ITEMS / 5, 0);
		run_random(RANDOM_ITEMS / 5, 81);
		run_random(RANDOM_ITEMS / 5, 6);
		run_random(RANDOM_ITEMS / 5, 0);
		run_random(RANDOM_ITEMS / 5, 81);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
